// ===== hdl/bump_map_lighting_pixel_macros.svh =====
// Assertion macros shared by the bump-map lighting pixel modules.
// Each check is sampled at the rising edge of clk and is off while rst is high.
`ifndef BUMP_MAP_LIGHTING_PIXEL_MACROS_SVH
`define BUMP_MAP_LIGHTING_PIXEL_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BML_ASSERT_NOW(label, cond_a, cond_c) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_c)) \
    else $error("bump map lighting check failed");
`define BML_ASSERT_NEXT(label, cond_a, cond_c) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_c)) \
    else $error("bump map lighting check failed");
`else
`define BML_ASSERT_NOW(label, cond_a, cond_c)
`define BML_ASSERT_NEXT(label, cond_a, cond_c)
`endif

`endif

// ===== hdl/bml_pkg.sv =====
package bml_pkg;

  typedef enum logic [2:0] {
    REG_LIGHT_X      = 3'd0,
    REG_LIGHT_Y      = 3'd1,
    REG_BUMP_DEPTH   = 3'd2,
    REG_BLEND_MODE   = 3'd3,
    REG_INVERT_DEPTH = 3'd4,
    REG_SAME_BUFFER  = 3'd5
  } reg_index_t;

  localparam logic [1:0] BLEND_REPLACE = 2'd0;
  localparam logic [1:0] BLEND_ADD     = 2'd1;
  localparam logic [1:0] BLEND_MEAN    = 2'd2;

  localparam logic [11:0] LIGHT_X_RESET    = 12'd1024;
  localparam logic [11:0] LIGHT_Y_RESET    = 12'd1024;
  localparam logic [6:0]  BUMP_DEPTH_RESET = 7'd30;

  localparam logic [7:0] CHAN_LIMIT = 8'd254;
  localparam logic [7:0] GRAD_BASE  = 8'd127;
  // floor(x * 256 / 100) == floor(x * 5243 / 2^11) for every 7-bit x.
  localparam logic [12:0] PCT_RECIP = 13'd5243;
  localparam int          PCT_SHIFT = 11;
  localparam int          LIT_SHIFT = 8 + 6;

  typedef struct packed {
    logic [11:0] light_x;
    logic [11:0] light_y;
    logic [6:0]  bump_depth;
    logic [1:0]  blend_mode;
    logic        invert_depth;
    logic        same_buffer;
  } cfg_t;

  typedef struct packed {
    logic [23:0]        src;
    logic signed [9:0]  hd;
    logic signed [9:0]  vd;
    logic signed [12:0] lx;
    logic signed [12:0] ly;
    logic               skip;
  } front_t;

  typedef struct packed {
    logic [23:0] src;
    logic [6:0]  t1;
    logic [6:0]  t2;
    logic [8:0]  scale;
    logic        ok;
    logic        skip;
  } grad_t;

  typedef struct packed {
    logic [23:0] src;
    logic [8:0]  add;
    logic        skip;
  } lit_t;

  function automatic logic [7:0] depth_of(input logic [23:0] pix, input logic inv);
    logic [7:0] m;
    m = pix[7:0];
    if (pix[15:8] > m) m = pix[15:8];
    if (pix[23:16] > m) m = pix[23:16];
    return inv ? (8'd255 - m) : m;
  endfunction

endpackage

// ===== hdl/bml_front.sv =====
module bml_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  bml_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        src_pixel,
  input  logic [23:0]        depth_left,
  input  logic [23:0]        depth_right,
  input  logic [23:0]        depth_up,
  input  logic [23:0]        depth_down,
  input  logic [10:0]        pos_x,
  input  logic [10:0]        pos_y,
  output logic               out_valid,
  input  logic               out_ready,
  output bml_pkg::front_t    out_data
);

  localparam int CMP_W = 14;

  logic [11:0]     cx;
  logic [11:0]     cy;
  logic [7:0]      d_l, d_r, d_u, d_d;
  bml_pkg::front_t front_next;

  // The light position saturates at the frame size.
  assign cx = ({2'b00, cfg.light_x} > CMP_W'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : cfg.light_x;
  assign cy = ({2'b00, cfg.light_y} > CMP_W'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : cfg.light_y;

  always_comb begin
    d_l = bml_pkg::depth_of(depth_left, cfg.invert_depth);
    d_r = bml_pkg::depth_of(depth_right, cfg.invert_depth);
    d_u = bml_pkg::depth_of(depth_up, cfg.invert_depth);
    d_d = bml_pkg::depth_of(depth_down, cfg.invert_depth);
    front_next.src  = src_pixel;
    front_next.hd   = $signed({2'b00, d_r}) - $signed({2'b00, d_l});
    front_next.vd   = $signed({2'b00, d_d}) - $signed({2'b00, d_u});
    front_next.lx   = $signed({2'b00, pos_x}) - $signed({1'b0, cx});
    front_next.ly   = $signed({2'b00, pos_y}) - $signed({1'b0, cy});
    front_next.skip = cfg.same_buffer && (depth_left == 24'd0) && (depth_right == 24'd0)
                      && (depth_up == 24'd0) && (depth_down == 24'd0);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= front_next;
    end
  end

endmodule

// ===== hdl/bml_grad.sv =====
`include "bump_map_lighting_pixel_macros.svh"

module bml_grad (
  input  logic               clk,
  input  logic               rst,
  input  logic [6:0]         bump_depth,
  input  logic               in_valid,
  output logic               in_ready,
  input  bml_pkg::front_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bml_pkg::grad_t     out_data
);

  logic signed [13:0] dx, dy;
  logic [13:0]        ax, ay;
  logic [19:0]        pct_prod;
  bml_pkg::grad_t     grad_next;

  always_comb begin
    dx = 14'(in_data.hd) - 14'(in_data.lx);
    dy = 14'(in_data.vd) - 14'(in_data.ly);
    ax = dx[13] ? 14'(-dx) : 14'(dx);
    ay = dy[13] ? 14'(-dy) : 14'(dy);
    pct_prod = 20'(bump_depth) * 20'(bml_pkg::PCT_RECIP);
    grad_next.src   = in_data.src;
    // A term is positive only while the absolute difference stays below 127.
    grad_next.ok    = (ax < 14'(bml_pkg::GRAD_BASE)) && (ay < 14'(bml_pkg::GRAD_BASE));
    grad_next.t1    = 7'(bml_pkg::GRAD_BASE - {1'b0, ax[6:0]});
    grad_next.t2    = 7'(bml_pkg::GRAD_BASE - {1'b0, ay[6:0]});
    grad_next.scale = pct_prod[bml_pkg::PCT_SHIFT +: 9];
    grad_next.skip  = in_data.skip;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= grad_next;
    end
  end

  `BML_ASSERT_NOW(a_terms_positive, out_valid && out_data.ok, (out_data.t1 != 7'd0) && (out_data.t2 != 7'd0))

endmodule

// ===== hdl/bml_mult.sv =====
module bml_mult (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bml_pkg::grad_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bml_pkg::lit_t      out_data
);

  // First product stage: t1 * t2.
  logic        a_valid;
  logic        a_ready;
  logic [23:0] a_src;
  logic [13:0] a_prod;
  logic [8:0]  a_scale;
  logic        a_ok;
  logic        a_skip;

  logic        b_ready;
  logic [22:0] b_prod;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;
  assign b_prod   = 23'(a_prod) * 23'(a_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_src   <= in_data.src;
      a_prod  <= 14'(in_data.t1) * 14'(in_data.t2);
      a_scale <= in_data.scale;
      a_ok    <= in_data.ok;
      a_skip  <= in_data.skip;
    end
    if (b_ready && a_valid) begin
      out_data.src  <= a_src;
      out_data.add  <= a_ok ? b_prod[bml_pkg::LIT_SHIFT +: 9] : 9'd0;
      out_data.skip <= a_skip;
    end
  end

endmodule

// ===== hdl/bml_blend.sv =====
`include "bump_map_lighting_pixel_macros.svh"

module bml_blend (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         blend_mode,
  input  logic               in_valid,
  output logic               in_ready,
  input  bml_pkg::lit_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_pixel
);

  logic [9:0]  lit_sum [3];
  logic [7:0]  lit_ch  [3];
  logic [8:0]  add_sum [3];
  logic [7:0]  src_ch  [3];
  logic [23:0] pix_next;

  always_comb begin
    pix_next = 24'd0;
    for (int k = 0; k < 3; k++) begin
      src_ch[k]  = in_data.src[8*k +: 8];
      lit_sum[k] = 10'(src_ch[k]) + 10'(in_data.add);
      lit_ch[k]  = (lit_sum[k] > 10'(bml_pkg::CHAN_LIMIT)) ? bml_pkg::CHAN_LIMIT
                                                           : lit_sum[k][7:0];
      add_sum[k] = 9'(src_ch[k]) + 9'(lit_ch[k]);
      case (blend_mode)
        bml_pkg::BLEND_ADD: begin
          pix_next[8*k +: 8] = add_sum[k][8] ? 8'hFF : add_sum[k][7:0];
        end
        bml_pkg::BLEND_MEAN: begin
          pix_next[8*k +: 8] = {1'b0, src_ch[k][7:1]} + {1'b0, lit_ch[k][7:1]};
        end
        default: begin
          pix_next[8*k +: 8] = lit_ch[k];
        end
      endcase
    end
    if (in_data.skip) begin
      pix_next = 24'd0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_pixel <= pix_next;
    end
  end

  // In replace mode no channel can reach full scale.
  `BML_ASSERT_NEXT(a_replace_limit, in_valid && in_ready && (blend_mode == bml_pkg::BLEND_REPLACE), (out_pixel[7:0] != 8'hFF) && (out_pixel[15:8] != 8'hFF) && (out_pixel[23:16] != 8'hFF))

endmodule

// ===== hdl/bump_map_lighting_pixel.sv =====
// A word accepted on s_tready passes the front, grad, mult and blend registers before it shows on m_tvalid.
// Throughput: one word per clock; the five register stages each stall only when
// the stage after them is full, so bubbles close up and the output register
// can hold a result while new words keep entering.
// Reset (rst, synchronous): valid bits clear and the registers return to
// light 1024/1024, depth 30, replace, no inversion, same buffer.
`include "bump_map_lighting_pixel_macros.svh"

module bump_map_lighting_pixel #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_addr,
  input  logic [11:0]   cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  // src_pixel, depth_left, depth_right, depth_up, depth_down, pos_x, pos_y, 2 zero bits
  input  logic [143:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // out_pixel
  output logic [23:0]   m_tdata
);

  bml_pkg::cfg_t   cfg;
  logic            f_valid, f_ready;
  bml_pkg::front_t f_data;
  logic            g_valid, g_ready;
  bml_pkg::grad_t  g_data;
  logic            l_valid, l_ready;
  bml_pkg::lit_t   l_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_x      <= bml_pkg::LIGHT_X_RESET;
      cfg.light_y      <= bml_pkg::LIGHT_Y_RESET;
      cfg.bump_depth   <= bml_pkg::BUMP_DEPTH_RESET;
      cfg.blend_mode   <= bml_pkg::BLEND_REPLACE;
      cfg.invert_depth <= 1'b0;
      cfg.same_buffer  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        bml_pkg::REG_LIGHT_X:      cfg.light_x      <= cfg_data;
        bml_pkg::REG_LIGHT_Y:      cfg.light_y      <= cfg_data;
        bml_pkg::REG_BUMP_DEPTH:   cfg.bump_depth   <= cfg_data[6:0];
        bml_pkg::REG_BLEND_MODE:   cfg.blend_mode   <= cfg_data[1:0];
        bml_pkg::REG_INVERT_DEPTH: cfg.invert_depth <= cfg_data[0];
        bml_pkg::REG_SAME_BUFFER:  cfg.same_buffer  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bml_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .src_pixel   (s_tdata[23:0]),
    .depth_left  (s_tdata[47:24]),
    .depth_right (s_tdata[71:48]),
    .depth_up    (s_tdata[95:72]),
    .depth_down  (s_tdata[119:96]),
    .pos_x       (s_tdata[130:120]),
    .pos_y       (s_tdata[141:131]),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_data    (f_data)
  );

  bml_grad u_grad (
    .clk        (clk),
    .rst        (rst),
    .bump_depth (cfg.bump_depth),
    .in_valid   (f_valid),
    .in_ready   (f_ready),
    .in_data    (f_data),
    .out_valid  (g_valid),
    .out_ready  (g_ready),
    .out_data   (g_data)
  );

  bml_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_data   (g_data),
    .out_valid (l_valid),
    .out_ready (l_ready),
    .out_data  (l_data)
  );

  bml_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .blend_mode (cfg.blend_mode),
    .in_valid   (l_valid),
    .in_ready   (l_ready),
    .in_data    (l_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_pixel  (m_tdata)
  );

  // With the output register empty, every stage can advance.
  `BML_ASSERT_NOW(a_empty_out_accepts, !m_tvalid, s_tready && f_ready && g_ready && l_ready)
  // A stage that holds a word while the next one is full keeps it.
  `BML_ASSERT_NEXT(a_front_hold, f_valid && !f_ready, f_valid)

endmodule

// ===== tb/lit_pixel_checker.sv =====
module lit_pixel_checker #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [11:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [23:0]  m_tdata,
  output int           pending,
  output int           errors
);
  timeunit 1ns;
  timeprecision 1ps;

  // Fields of one input word, last member in the lowest bits.
  typedef struct packed {
    logic [1:0]  fill;
    logic [10:0] pos_y;
    logic [10:0] pos_x;
    logic [23:0] depth_down;
    logic [23:0] depth_up;
    logic [23:0] depth_right;
    logic [23:0] depth_left;
    logic [23:0] src;
  } pixel_word_t;

  bml_pkg::cfg_t settings;
  logic [23:0]   expected_pixels[$];
  int            failures = 0;

  function automatic int height_of(logic [23:0] pix);
    int m;
    m = int'(pix[7:0]);
    if (int'(pix[15:8]) > m) m = int'(pix[15:8]);
    if (int'(pix[23:16]) > m) m = int'(pix[23:16]);
    return settings.invert_depth ? 255 - m : m;
  endfunction

  function automatic logic [23:0] shade_pixel(pixel_word_t w);
    int col, row, t1, t2, pct, boost, ch;
    logic [23:0] lit, res;
    if (settings.same_buffer && w.depth_left == 0 && w.depth_right == 0 &&
        w.depth_up == 0 && w.depth_down == 0)
      return 24'd0;
    col = (int'(settings.light_x) > MAX_WIDTH) ? MAX_WIDTH : int'(settings.light_x);
    row = (int'(settings.light_y) > MAX_HEIGHT) ? MAX_HEIGHT : int'(settings.light_y);
    t1 = height_of(w.depth_right) - height_of(w.depth_left) - (int'(w.pos_x) - col);
    t2 = height_of(w.depth_down) - height_of(w.depth_up) - (int'(w.pos_y) - row);
    t1 = int'(bml_pkg::GRAD_BASE) - ((t1 < 0) ? -t1 : t1);
    t2 = int'(bml_pkg::GRAD_BASE) - ((t2 < 0) ? -t2 : t2);
    boost = 0;
    if (t1 > 0 && t2 > 0) begin
      pct = int'(settings.bump_depth);
      boost = (t1 * t2 * ((pct * 256) / 100)) >>> bml_pkg::LIT_SHIFT;
    end
    for (int k = 0; k < 3; k++) begin
      ch = int'(w.src[8*k +: 8]) + boost;
      lit[8*k +: 8] = (ch > int'(bml_pkg::CHAN_LIMIT)) ? bml_pkg::CHAN_LIMIT : ch[7:0];
    end
    for (int k = 0; k < 3; k++) begin
      case (settings.blend_mode)
        bml_pkg::BLEND_ADD: begin
          ch = int'(w.src[8*k +: 8]) + int'(lit[8*k +: 8]);
          res[8*k +: 8] = (ch > 255) ? 8'hFF : ch[7:0];
        end
        bml_pkg::BLEND_MEAN: res[8*k +: 8] = (w.src[8*k +: 8] >> 1) + (lit[8*k +: 8] >> 1);
        default:             res[8*k +: 8] = lit[8*k +: 8];
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    logic [23:0] want;
    if (rst) begin
      expected_pixels.delete();
      settings = '{light_x: bml_pkg::LIGHT_X_RESET, light_y: bml_pkg::LIGHT_Y_RESET,
                   bump_depth: bml_pkg::BUMP_DEPTH_RESET,
                   blend_mode: bml_pkg::BLEND_REPLACE,
                   invert_depth: 1'b0, same_buffer: 1'b1};
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: out_pixel expected none, actual %06h", $time, m_tdata);
          failures++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: out_pixel expected %06h, actual %06h", $time, want, m_tdata);
            failures++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_pixels.push_back(shade_pixel(pixel_word_t'(s_tdata)));
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          bml_pkg::REG_LIGHT_X:      settings.light_x = cfg_data;
          bml_pkg::REG_LIGHT_Y:      settings.light_y = cfg_data;
          bml_pkg::REG_BUMP_DEPTH:   settings.bump_depth = cfg_data[6:0];
          bml_pkg::REG_BLEND_MODE:   settings.blend_mode = cfg_data[1:0];
          bml_pkg::REG_INVERT_DEPTH: settings.invert_depth = cfg_data[0];
          bml_pkg::REG_SAME_BUFFER:  settings.same_buffer = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending <= expected_pixels.size();
    errors  <= failures;
  end

endmodule

// ===== tb/tb_bump_map_lighting_pixel.sv =====
module tb_bump_map_lighting_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAME_LIMIT  = 2048;
  localparam int          RUN_LIMIT    = 300000;
  localparam logic [1:0]  BLEND_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  bml_pkg::reg_index_t cfg_addr = bml_pkg::REG_LIGHT_X;
  logic [11:0]         cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [143:0]        s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [23:0]         m_tdata;

  int pending;
  int errors;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int ready_idle_pct = 0;
  int aim_x = 1024;
  int aim_y = 1024;

  always #4 clk = ~clk;

  bump_map_lighting_pixel u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  lit_pixel_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .pending(pending), .errors(errors)
  );

  always @(posedge clk) m_tready <= (int'($urandom_range(99)) >= ready_idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("bump_map_lighting_pixel test failed");
      $finish;
    end
  end

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(bml_pkg::reg_index_t idx, logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(logic [11:0] lx, logic [11:0] ly, logic [11:0] depth,
                               logic [11:0] mode, logic [11:0] inv, logic [11:0] same);
    write_reg(bml_pkg::REG_LIGHT_X, lx);
    write_reg(bml_pkg::REG_LIGHT_Y, ly);
    write_reg(bml_pkg::REG_BUMP_DEPTH, depth);
    write_reg(bml_pkg::REG_BLEND_MODE, mode);
    write_reg(bml_pkg::REG_INVERT_DEPTH, inv);
    write_reg(bml_pkg::REG_SAME_BUFFER, same);
    cfg_valid <= 1'b0;
    aim_x = (int'(lx) > FRAME_LIMIT) ? FRAME_LIMIT : int'(lx);
    aim_y = (int'(ly) > FRAME_LIMIT) ? FRAME_LIMIT : int'(ly);
  endtask

  // Leaves s_tvalid high so back-to-back words need no extra step.
  task automatic send_pixel(logic [23:0] src, logic [23:0] dl, logic [23:0] dr,
                            logic [23:0] du, logic [23:0] dd,
                            logic [10:0] px, logic [10:0] py);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, py, px, dd, du, dr, dl, src};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [23:0] random_depth();
    logic [23:0] v;
    v = 24'($urandom());
    case ($urandom_range(3))
      0: return v;
      1: return {16'd0, v[7:0]} << (8 * $urandom_range(2));
      2: return {3{v[7:0]}};
      default: return v & 24'h1F1F1F;
    endcase
  endfunction

  function automatic logic [10:0] near_light(int aim);
    int p;
    if ($urandom_range(9) < 2) return 11'($urandom_range(2047));
    p = aim + int'($urandom_range(400)) - 200;
    if (p < 0) p = 0;
    if (p > 2047) p = 2047;
    return p[10:0];
  endfunction

  task automatic send_random_pixel();
    logic [23:0] dl, dr, du, dd;
    if ($urandom_range(19) == 0) begin
      dl = '0; dr = '0; du = '0; dd = '0;
    end else begin
      dl = random_depth();
      dr = random_depth();
      du = random_depth();
      dd = random_depth();
    end
    send_pixel(24'($urandom()), dl, dr, du, dd, near_light(aim_x), near_light(aim_y));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: light at the frame center, depth 30, replace, same buffer.
    send_idle_pct  = 25;
    ready_idle_pct = 46;
    send_pixel(24'hA5C3E1, 24'h0, 24'h0, 24'h0, 24'h0, 11'd1024, 11'd1024);
    send_pixel(24'h000000, 24'h808080, 24'h808080, 24'h808080, 24'h808080,
               11'd1024, 11'd1024);
    send_pixel(24'hFFFFFF, 24'h808080, 24'h808080, 24'h808080, 24'h808080,
               11'd1024, 11'd1024);
    // Horizontal term exactly zero, then just above zero.
    send_pixel(24'hFE01FF, 24'h0, 24'h00007F, 24'h10, 24'h10, 11'd1024, 11'd1024);
    send_pixel(24'hFE01FF, 24'h0, 24'h00007E, 24'h10, 24'h10, 11'd1024, 11'd1024);
    // Vertical term exactly zero.
    send_pixel(24'h123456, 24'h1, 24'h1, 24'h0, 24'h7F0000, 11'd1024, 11'd1024);
    send_pixel(24'h3C3C3C, 24'hFF0000, 24'h0, 24'hFF, 24'hFF, 11'd1024, 11'd1024);
    send_pixel(24'h404040, 24'h404040, 24'h404040, 24'h404040, 24'h404040, 11'd0, 11'd0);
    send_pixel(24'h404040, 24'h404040, 24'h404040, 24'h404040, 24'h404040,
               11'd2047, 11'd2047);
    send_pixel(24'h7F0080, 24'h202020, 24'h202020, 24'h202020, 24'h202020, 11'd1, 11'd1);
    send_pixel(24'h7F0080, 24'h202020, 24'h202020, 24'h202020, 24'h202020,
               11'd2046, 11'd2046);
    // Gradient offsets that cancel the light offset.
    send_pixel(24'h204060, 24'h0, 24'h640000, 24'h5, 24'h5, 11'd1124, 11'd1024);
    send_pixel(24'h204060, 24'h006400, 24'h0, 24'h5, 24'h5, 11'd924, 11'd1024);
    send_pixel(24'h204060, 24'h5, 24'h5, 24'h006400, 24'h0, 11'd1024, 11'd924);
    send_pixel(24'hFFFFFF, 24'h0, 24'h0, 24'h0, 24'h000001, 11'd1024, 11'd1024);
    send_pixel(24'h7F7F7F, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
               11'd1024, 11'd1024);
    send_pixel(24'h010203, 24'h00FF00, 24'h00FF00, 24'h0000FF, 24'hFF0000,
               11'd1024, 11'd1024);
    send_pixel(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
               11'h555, 11'h2AA);
    send_pixel(24'hFEFEFE, 24'h0F0F0F, 24'h0F0F0F, 24'h0F0F0F, 24'h0F0F0F,
               11'h2AA, 11'h555);

    for (int phase = 0; phase < 8; phase++) begin
      wait_all_results();
      case (phase)
        0: apply_setting(12'd0, 12'd0, 12'd100, 12'(bml_pkg::BLEND_ADD), 12'd0, 12'd1);
        1: apply_setting(12'd2048, 12'd2048, 12'd0, 12'(bml_pkg::BLEND_MEAN), 12'd1, 12'd0);
        2: apply_setting(12'd4095, 12'd4095, 12'd127, 12'(BLEND_UNUSED), 12'd0, 12'd0);
        3: apply_setting(12'd700, 12'd1500, 12'd50, 12'(bml_pkg::BLEND_REPLACE), 12'd1, 12'd1);
        4: apply_setting(12'd2047, 12'd1, 12'd100, 12'(bml_pkg::BLEND_ADD), 12'd1, 12'd0);
        5: apply_setting(12'd300, 12'd2100, 12'd75, 12'(bml_pkg::BLEND_MEAN), 12'd0, 12'd1);
        6: apply_setting(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                         12'($urandom_range(4095)), 12'($urandom_range(4095)),
                         12'($urandom_range(4095)), 12'($urandom_range(4095)));
        default: apply_setting(12'd1024, 12'd1024, 12'd127, 12'(bml_pkg::BLEND_REPLACE),
                               12'd0, 12'd0);
      endcase
      if (phase < 3) begin
        send_idle_pct  = 25;
        ready_idle_pct = 46;
      end else if (phase < 6) begin
        send_idle_pct  = 46;
        ready_idle_pct = 25;
      end else begin
        send_idle_pct  = 0;
        ready_idle_pct = 0;
      end
      repeat (60) send_random_pixel();
    end

    wait_all_results();
    repeat (12) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("bump_map_lighting_pixel test passed");
    else
      $display("bump_map_lighting_pixel test failed");
    $finish;
  end

endmodule
